// ===== sv/polyphonic_voice_allocator_top_assert.svh =====
// Assertion macros for the polyphonic voice allocator top level.
// Depends on nothing; the including module supplies clock and reset.
`ifndef POLYPHONIC_VOICE_ALLOCATOR_TOP_ASSERT_SVH
`define POLYPHONIC_VOICE_ALLOCATOR_TOP_ASSERT_SVH

// Condition that must hold on every cycle out of reset.
`define PVA_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Antecedent that implies a consequent in the same cycle.
`define PVA_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== sv/pva_pkg.sv =====
// Shared types and constants for the polyphonic voice allocator.
// No dependencies; imported by the controller, datapath and top level.
package pva_pkg;

   localparam int STORE_DEPTH = 16;
   localparam int NOTE_W      = 7;
   localparam int VOICE_W     = 4;
   localparam int IDX_W       = 4;
   localparam int COUNT_W     = 5;

   localparam logic CMD_NOTE_ON  = 1'b0;
   localparam logic CMD_NOTE_OFF = 1'b1;

   localparam logic [1:0] EV_GATE_ON  = 2'd0;
   localparam logic [1:0] EV_GATE_OFF = 2'd1;
   localparam logic [1:0] EV_STEAL    = 2'd2;

   typedef struct packed {
      logic              command;
      logic [NOTE_W-1:0] note_number;
   } pva_req_type;

   typedef struct packed {
      logic [1:0]         event_kind;
      logic [VOICE_W-1:0] voice;
      logic [NOTE_W-1:0]  note_out;
      logic               last;
   } pva_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEAL,
      ST_SEARCH,
      ST_GATE,
      ST_OFF_SCAN
   } pva_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture request, seed search and scan
      logic steal;     // emit oldest entry as stolen, drop it
      logic step;      // advance round-robin candidate
      logic gate;      // emit gate-on, append entry
      logic off_emit;  // emit gate-off for scanned entry, drop it
      logic off_next;  // move scan index down
   } pva_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic               full;
      logic               empty;
      logic               slot_free;
      logic               search_done;
      logic               scan_match;
      logic               idx_zero;
      logic [COUNT_W-1:0] count;
      logic [COUNT_W-1:0] limit;
   } pva_status_type;

endpackage

// ===== sv/pva_ctrl.sv =====
// Sequencer for the voice allocator: note-on steal/search/gate and note-off scan.
// Depends on pva_pkg; drives the datapath through pva_cmd_type.
module pva_ctrl
   import pva_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_command,
   output logic           req_ready,
   input  pva_status_type status,
   output pva_cmd_type    cmd
);

   pva_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_command == CMD_NOTE_ON) begin
                  state_in = status.full ? ST_STEAL : ST_SEARCH;
               end else begin
                  state_in = status.empty ? ST_IDLE : ST_OFF_SCAN;
               end
            end
         end
         ST_STEAL: begin
            if (status.slot_free) begin
               cmd.steal = 1'b1;
               state_in  = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.step = 1'b1;
            if (status.search_done) begin
               state_in = ST_GATE;
            end
         end
         ST_GATE: begin
            if (status.slot_free) begin
               cmd.gate = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_OFF_SCAN: begin
            // hold on a match until the output slot frees up
            if (!status.scan_match || status.slot_free) begin
               cmd.off_emit = status.scan_match;
               cmd.off_next = 1'b1;
               if (status.idx_zero) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== sv/pva_datapath.sv =====
// Held-note list, round-robin search, voice-limit register and result register.
// Depends on pva_pkg; commanded by pva_ctrl.
module pva_datapath
   import pva_pkg::*;
#(
   parameter int MAX_VOICES = 16
)
(
   input  logic           clock,
   input  logic           reset,
   input  pva_req_type    req_payload,
   input  logic           csr_valid,
   input  logic [4:0]     csr_data,
   input  pva_cmd_type    cmd,
   output pva_status_type status,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output pva_rsp_type    rsp_payload
);

   localparam int CAP_INT = (MAX_VOICES > STORE_DEPTH) ? STORE_DEPTH : MAX_VOICES;
   localparam logic [COUNT_W-1:0] CAP = COUNT_W'(CAP_INT);

   logic [NOTE_W-1:0]  held_note_ff  [STORE_DEPTH];
   logic [VOICE_W-1:0] held_voice_ff [STORE_DEPTH];
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [VOICE_W-1:0] last_ff, last_in;
   logic [COUNT_W-1:0] limit_ff, limit_in;
   logic [VOICE_W-1:0] cand_ff, cand_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [NOTE_W-1:0]  note_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   pva_rsp_type        rsp_ff, rsp_in;

   logic [VOICE_W-1:0]  cand_next;
   logic [STORE_DEPTH-1:0] used_vec;
   logic [STORE_DEPTH-1:0] match_vec;
   logic [STORE_DEPTH-1:0] below_vec;
   logic                remove_en;
   logic [IDX_W-1:0]    remove_at;
   logic                emit;
   logic [COUNT_W-1:0]  count_dec;

   assign count_dec = count_ff - COUNT_W'(1);
   assign cand_next = ({1'b0, cand_ff} == (limit_ff - COUNT_W'(1))) ? '0
                                                                   : cand_ff + VOICE_W'(1);

   always_comb begin
      for (int j = 0; j < STORE_DEPTH; j++) begin
         used_vec[j]  = (COUNT_W'(j) < count_ff) && (held_voice_ff[j] == cand_next);
         match_vec[j] = (held_note_ff[j] == note_ff);
         below_vec[j] = match_vec[j] && (IDX_W'(j) < idx_ff);
      end
   end

   assign remove_en = cmd.steal || cmd.off_emit;
   assign remove_at = cmd.steal ? '0 : idx_ff;
   assign emit      = cmd.steal || cmd.gate || cmd.off_emit;

   always_comb begin
      limit_in = limit_ff;
      if (csr_valid) begin
         priority if (csr_data == '0) begin
            limit_in = COUNT_W'(1);
         end else if (csr_data > CAP) begin
            limit_in = CAP;
         end else begin
            limit_in = csr_data;
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      last_in  = last_ff;
      priority if (csr_valid) begin
         count_in = '0;
         last_in  = '0;
      end else if (cmd.gate) begin
         count_in = count_ff + COUNT_W'(1);
         last_in  = cand_ff;
      end else if (remove_en) begin
         count_in = count_dec;
      end
   end

   always_comb begin
      cand_in = cand_ff;
      idx_in  = idx_ff;
      if (cmd.load) begin
         cand_in = last_ff;
         idx_in  = count_dec[IDX_W-1:0];
      end
      if (cmd.step) begin
         cand_in = cand_next;
      end
      if (cmd.off_next) begin
         idx_in = idx_ff - IDX_W'(1);
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      unique case (1'b1)
         cmd.steal: begin
            rsp_in.event_kind = EV_STEAL;
            rsp_in.voice      = held_voice_ff[0];
            rsp_in.note_out   = held_note_ff[0];
            rsp_in.last       = 1'b0;
         end
         cmd.gate: begin
            rsp_in.event_kind = EV_GATE_ON;
            rsp_in.voice      = cand_ff;
            rsp_in.note_out   = note_ff;
            rsp_in.last       = 1'b1;
         end
         cmd.off_emit: begin
            rsp_in.event_kind = EV_GATE_OFF;
            rsp_in.voice      = held_voice_ff[idx_ff];
            rsp_in.note_out   = note_ff;
            rsp_in.last       = ~|below_vec;
         end
         default: rsp_in = rsp_ff;
      endcase
      rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         last_ff      <= '0;
         limit_ff     <= CAP;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         last_ff      <= last_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff <= cand_in;
      idx_ff  <= idx_in;
      rsp_ff  <= rsp_in;
      if (cmd.load) begin
         note_ff <= req_payload.note_number;
      end
   end

   // compact the list above a removed entry; append at the fill point
   always_ff @(posedge clock) begin
      for (int j = 0; j < STORE_DEPTH; j++) begin
         if (remove_en && (IDX_W'(j) >= remove_at) && (j < STORE_DEPTH - 1)) begin
            held_note_ff[j]  <= held_note_ff[(j + 1) % STORE_DEPTH];
            held_voice_ff[j] <= held_voice_ff[(j + 1) % STORE_DEPTH];
         end else if (cmd.gate && (count_ff[IDX_W-1:0] == IDX_W'(j))) begin
            held_note_ff[j]  <= note_ff;
            held_voice_ff[j] <= cand_ff;
         end
      end
   end

   assign status.full        = (count_ff >= limit_ff) && (count_ff != '0);
   assign status.empty       = (count_ff == '0);
   assign status.slot_free   = !rsp_valid_ff || rsp_ready;
   assign status.search_done = !(|used_vec) || (cand_next == last_ff);
   assign status.scan_match  = match_vec[idx_ff];
   assign status.idx_zero    = (idx_ff == '0);
   assign status.count       = count_ff;
   assign status.limit       = limit_ff;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== sv/polyphonic_voice_allocator_top.sv =====
// Polyphonic voice allocator: round-robin voice assignment with oldest-note stealing.
// Channels: req_ (note events in), rsp_ (voice events out), csr_ (voice_limit write).
// Each transfer on req_ is a note-on or note-off; it yields zero or more rsp_ transfers,
// the final one flagged by last. A note-on yields an optional steal, then a gate-on.
// A note-off yields one gate-off per held entry with that note, newest first.
// A note-on tries round-robin candidates in turn (up to voice_limit), after a steal
// when one is needed. A note-off scans the held entries from newest to oldest. The
// shared candidate register and the single scan index mean that one event is worked
// at a time.
// rsp_ is registered: a result waits there while the block prepares the next one.
// When the receiver stalls, the sequencer holds before emitting the next result.
// A csr_ write clamps voice_limit into 1..min(MAX_VOICES,16), clears the held list
// and the last assigned voice; it is taken in any cycle and is meant for idle time.
// Reset (synchronous, active high) empties the list, sets voice_limit to its maximum
// and the last assigned voice to 0; no clearing pass is needed.
module polyphonic_voice_allocator_top
   import pva_pkg::*;
#(
   parameter int MAX_VOICES = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  pva_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output pva_rsp_type rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data
);

   pva_cmd_type    cmd;
   pva_status_type status;
   logic           rsp_gate_on;
   logic           rsp_steal;
   logic           gate_voice_ok;

   assign csr_ready = 1'b1;

   pva_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_payload.command),
      .req_ready   (req_ready),
      .status      (status),
      .cmd         (cmd)
   );

   pva_datapath #(
      .MAX_VOICES (MAX_VOICES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   assign rsp_gate_on   = rsp_valid && (rsp_payload.event_kind == EV_GATE_ON);
   assign rsp_steal     = rsp_valid && (rsp_payload.event_kind == EV_STEAL);
   assign gate_voice_ok = {1'b0, rsp_payload.voice} < status.limit;

`include "polyphonic_voice_allocator_top_assert.svh"

   `PVA_ASSERT_ALWAYS(a_count_le_limit, status.count <= status.limit, "held count above limit")
   `PVA_ASSERT_ALWAYS(a_limit_nonzero, status.limit != '0, "voice limit is zero")
   `PVA_ASSERT_IMPLIES(a_gate_voice_ok, rsp_gate_on, gate_voice_ok, "gate-on voice beyond limit")
   `PVA_ASSERT_IMPLIES(a_steal_not_last, rsp_steal, !rsp_payload.last, "steal flagged as last")

endmodule
